// ----- rtl/pvog_pkg.sv -----
`default_nettype none

package pvog_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned WORD_SEL_W  = 12;
  localparam int unsigned BIT_SEL_W   = 6;
  localparam int unsigned IDX_W       = WORD_SEL_W + BIT_SEL_W;
  localparam int unsigned STORE_DEPTH = 1 << WORD_SEL_W;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE = 2'd3;

  localparam logic [COORD_W-1:0] CELL_SCALE_RESET = 32'd4194304;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic                            mode;
    logic signed [COORD_W-1:0]       point_x;
    logic signed [COORD_W-1:0]       point_y;
    logic signed [COORD_W-1:0]       point_z;
    logic        [WORD_SEL_W-1:0]    word_select;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] occupancy_word;
    logic [IDX_W-1:0]  voxel_index;
    logic              out_of_range;
  } out_t;

  // voxel mapping result handed to the control
  typedef struct packed {
    logic             valid;
    logic             in_grid;
    logic [IDX_W-1:0] voxel_index;
  } map_res_t;

  // access request to the occupancy store
  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic [WORD_SEL_W-1:0] addr;
    logic [WORD_W-1:0]     wdata;
  } store_req_t;

endpackage

`default_nettype wire

// ----- rtl/pvog_map.sv -----
`default_nettype none

module pvog_map #(
  parameter int unsigned GRID_N = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [pvog_pkg::COORD_W-1:0]  point_x_i,
  input  wire logic signed [pvog_pkg::COORD_W-1:0]  point_y_i,
  input  wire logic signed [pvog_pkg::COORD_W-1:0]  point_z_i,
  input  wire logic signed [pvog_pkg::COORD_W-1:0]  origin_x_i,
  input  wire logic signed [pvog_pkg::COORD_W-1:0]  origin_y_i,
  input  wire logic signed [pvog_pkg::COORD_W-1:0]  origin_z_i,
  input  wire logic        [pvog_pkg::COORD_W-1:0]  scale_i,
  output pvog_pkg::map_res_t                        res_o
);

  localparam int unsigned CW    = (GRID_N > 1) ? $clog2(GRID_N) : 1;
  localparam int unsigned LIN_W = 3 * CW;
  localparam int unsigned DW    = pvog_pkg::COORD_W + 1;
  localparam int unsigned PW    = 2 * pvog_pkg::COORD_W;
  localparam int unsigned EXT_W = LIN_W + pvog_pkg::IDX_W;
  localparam logic [LIN_W-1:0] ROW   = LIN_W'(GRID_N);
  localparam logic [LIN_W-1:0] PLANE = LIN_W'(GRID_N * GRID_N);
  localparam logic [pvog_pkg::COORD_W-1:0] LIMIT = pvog_pkg::COORD_W'(GRID_N);

  logic signed [pvog_pkg::COORD_W-1:0] pt  [3];
  logic signed [pvog_pkg::COORD_W-1:0] org [3];

  logic                 s1_valid_q, s2_valid_q;
  logic signed [DW-1:0] d_q    [3];
  logic                 neg_q  [3];
  logic [PW-1:0]        prod_q [3];
  pvog_pkg::map_res_t   res_q, res_d;

  assign pt[0]  = point_x_i;
  assign pt[1]  = point_y_i;
  assign pt[2]  = point_z_i;
  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      res_q      <= '0;
    end else begin
      s1_valid_q <= start_i;
      s2_valid_q <= s1_valid_q;
      res_q      <= res_d;
    end
  end

  // exact difference, then the Q32.32 product per axis
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (start_i) begin
        d_q[a] <= DW'(pt[a]) - DW'(org[a]);
      end
      if (s1_valid_q) begin
        neg_q[a]  <= d_q[a][DW-1];
        prod_q[a] <= PW'(d_q[a][pvog_pkg::COORD_W-1:0]) * PW'(scale_i);
      end
    end
  end

  always_comb begin
    logic [pvog_pkg::COORD_W-1:0] floor_v;
    logic [CW-1:0]                vox_c [3];
    logic                         ok;
    logic [LIN_W-1:0]             lin;
    logic [EXT_W-1:0]             lin_ext;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      floor_v  = prod_q[a][PW-1:pvog_pkg::COORD_W];
      vox_c[a] = floor_v[CW-1:0];
      // negative offset lands below the grid unless the scale is zero
      if ((neg_q[a] && (scale_i != '0)) || (floor_v >= LIMIT)) begin
        ok = 1'b0;
      end
    end
    lin     = LIN_W'(vox_c[2]) * PLANE + LIN_W'(vox_c[1]) * ROW + LIN_W'(vox_c[0]);
    lin_ext = EXT_W'(lin);
    if (lin_ext[EXT_W-1:pvog_pkg::IDX_W] != '0) begin
      ok = 1'b0;
    end
    res_d.valid       = s2_valid_q;
    res_d.in_grid     = ok;
    res_d.voxel_index = ok ? lin_ext[pvog_pkg::IDX_W-1:0] : '0;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/pvog_store.sv -----
`default_nettype none

module pvog_store (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pvog_pkg::store_req_t        req_i,
  output logic [pvog_pkg::WORD_W-1:0]      rdata_o,
  output logic                             clr_busy_o
);

  logic [pvog_pkg::WORD_W-1:0]     mem_q [pvog_pkg::STORE_DEPTH];
  logic [pvog_pkg::WORD_W-1:0]     rdata_q;
  logic                            clr_active_q;
  logic [pvog_pkg::WORD_SEL_W-1:0] clr_addr_q;

  logic                            wr_en;
  logic [pvog_pkg::WORD_SEL_W-1:0] wr_addr;
  logic [pvog_pkg::WORD_W-1:0]     wr_data;

  // sweep every word to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  assign wr_en   = clr_active_q || req_i.wr;
  assign wr_addr = clr_active_q ? clr_addr_q : req_i.addr;
  assign wr_data = clr_active_q ? '0 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_active_q;

endmodule

`default_nettype wire

// ----- rtl/point_voxel_occupancy_grid.sv -----
// Insert word: mapped by pvog_map, then its store word is read, and the result is registered
// in ST_MODIFY. Read word: store read on acceptance, result registered in ST_MODIFY.
// One word is in flight at a time; the single-port occupancy store carries one
// read-modify-write per word; a full, stalled output register stalls the write-back.
// Reset (async, active low) restores the registers and then sweeps the store to
// zero, one word a cycle across all 4096 words, with in_stall_o high throughout.
`default_nettype none

module point_voxel_occupancy_grid #(
  parameter int unsigned GRID_N = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire pvog_pkg::in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output pvog_pkg::out_t                           out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [pvog_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [pvog_pkg::COORD_W-1:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_MODIFY,
    ST_REJECT
  } state_e;

  state_e                          state_q;
  logic signed [pvog_pkg::COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic [pvog_pkg::COORD_W-1:0]    scale_q;
  logic                            mode_q;
  logic [pvog_pkg::WORD_SEL_W-1:0] addr_q;
  logic [pvog_pkg::BIT_SEL_W-1:0]  bit_q;
  logic [pvog_pkg::IDX_W-1:0]      idx_q;
  logic                            out_valid_q;
  pvog_pkg::out_t                  out_data_q;

  logic                            accept;
  logic                            slot_free;
  logic                            map_start;
  pvog_pkg::map_res_t              map_res;
  pvog_pkg::store_req_t            store_req;
  logic [pvog_pkg::WORD_W-1:0]     st_rdata;
  logic                            clr_busy;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign map_start  = accept && (in_data_i.mode == pvog_pkg::MODE_INSERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      scale_q    <= pvog_pkg::CELL_SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pvog_pkg::CFG_ORIGIN_X:   origin_x_q <= cfg_data_i;
        pvog_pkg::CFG_ORIGIN_Y:   origin_y_q <= cfg_data_i;
        pvog_pkg::CFG_ORIGIN_Z:   origin_z_q <= cfg_data_i;
        pvog_pkg::CFG_CELL_SCALE: scale_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pvog_map #(
    .GRID_N (GRID_N)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (map_start),
    .point_x_i  (in_data_i.point_x),
    .point_y_i  (in_data_i.point_y),
    .point_z_i  (in_data_i.point_z),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .origin_z_i (origin_z_q),
    .scale_i    (scale_q),
    .res_o      (map_res)
  );

  pvog_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (store_req),
    .rdata_o    (st_rdata),
    .clr_busy_o (clr_busy)
  );

  always_comb begin
    store_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.mode == pvog_pkg::MODE_READ)) begin
          store_req.rd   = 1'b1;
          store_req.addr = in_data_i.word_select;
        end
      end
      ST_MAP: begin
        if (map_res.valid && map_res.in_grid) begin
          store_req.rd   = 1'b1;
          store_req.addr = map_res.voxel_index[pvog_pkg::IDX_W-1:pvog_pkg::BIT_SEL_W];
        end
      end
      ST_MODIFY: begin
        // write back: cleared word on read, word with the voxel bit set on insert
        if (slot_free) begin
          store_req.wr   = 1'b1;
          store_req.addr = addr_q;
          store_req.wdata = (mode_q == pvog_pkg::MODE_READ) ? '0 :
                            (st_rdata | (pvog_pkg::WORD_W'(1) << bit_q));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= pvog_pkg::MODE_INSERT;
      addr_q      <= '0;
      bit_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // drop the taken word unless a new one is loaded below
      if (out_valid_q && !out_stall_i && (state_q != ST_MODIFY) &&
          (state_q != ST_REJECT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (!clr_busy) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            mode_q <= in_data_i.mode;
            if (in_data_i.mode == pvog_pkg::MODE_READ) begin
              addr_q  <= in_data_i.word_select;
              state_q <= ST_MODIFY;
            end else begin
              state_q <= ST_MAP;
            end
          end
        end
        ST_MAP: begin
          if (map_res.valid) begin
            if (map_res.in_grid) begin
              addr_q  <= map_res.voxel_index[pvog_pkg::IDX_W-1:pvog_pkg::BIT_SEL_W];
              bit_q   <= map_res.voxel_index[pvog_pkg::BIT_SEL_W-1:0];
              idx_q   <= map_res.voxel_index;
              state_q <= ST_MODIFY;
            end else begin
              state_q <= ST_REJECT;
            end
          end
        end
        ST_MODIFY: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_data_q.out_of_range <= 1'b0;
            if (mode_q == pvog_pkg::MODE_READ) begin
              out_data_q.occupancy_word <= st_rdata;
              out_data_q.voxel_index    <= '0;
            end else begin
              out_data_q.occupancy_word <= '0;
              out_data_q.voxel_index    <= idx_q;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_REJECT: begin
          if (slot_free) begin
            out_valid_q               <= 1'b1;
            out_data_q.occupancy_word <= '0;
            out_data_q.voxel_index    <= '0;
            out_data_q.out_of_range   <= 1'b1;
            state_q                   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("word accepted during store clear");

  a_write_in_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr |-> (state_q == ST_MODIFY) && !clr_busy)
    else $error("store write outside modify");

  a_read_then_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.rd |=> (state_q == ST_MODIFY))
    else $error("store read not followed by modify");

  a_map_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_res.valid |-> (state_q == ST_MAP))
    else $error("mapping result outside map state");

  a_reject_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.out_of_range |->
      (out_data_q.voxel_index == '0) && (out_data_q.occupancy_word == '0))
    else $error("out of range result carries data");
`endif

endmodule

`default_nettype wire
